### src/sevq_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the sorted event queue
package sevq_pkg;

    localparam int POS_W         = 32;
    localparam int HANDLE_PORT_W = 16;
    localparam int CAP_W         = 7;
    localparam int RANK_W        = 6;
    localparam int CMD_W         = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    typedef struct packed {
        logic ins;
        logic pop;
        logic tap_load;
        logic tap_shift;
    } t_cell_ctl;

endpackage

### src/sevq_cell.sv
`timescale 1ns / 1ps
// one cell of the sorted chain: an entry register and a readout tap register
module sevq_cell #(
    parameter int HW = 16
) (
    input  logic                          i_clk,
    input  sevq_pkg::t_cell_ctl           i_ctl,
    input  logic [sevq_pkg::POS_W-1:0]    i_new_pos,
    input  logic [HW-1:0]                 i_new_handle,
    input  logic                          i_occ,
    input  logic                          i_left_move,
    input  logic [sevq_pkg::POS_W-1:0]    i_left_pos,
    input  logic [HW-1:0]                 i_left_handle,
    input  logic [sevq_pkg::POS_W-1:0]    i_right_pos,
    input  logic [HW-1:0]                 i_right_handle,
    input  logic [sevq_pkg::POS_W-1:0]    i_right_tap_pos,
    input  logic [HW-1:0]                 i_right_tap_handle,
    output logic                          o_move,
    output logic [sevq_pkg::POS_W-1:0]    o_pos,
    output logic [HW-1:0]                 o_handle,
    output logic [sevq_pkg::POS_W-1:0]    o_tap_pos,
    output logic [HW-1:0]                 o_tap_handle
);

    logic [sevq_pkg::POS_W-1:0] r_pos;
    logic [HW-1:0]              r_handle;
    logic [sevq_pkg::POS_W-1:0] r_tap_pos;
    logic [HW-1:0]              r_tap_handle;
    logic [sevq_pkg::POS_W-1:0] n_pos;
    logic [HW-1:0]              n_handle;
    logic [sevq_pkg::POS_W-1:0] n_tap_pos;
    logic [HW-1:0]              n_tap_handle;

    // entries strictly greater than the new key, and empty slots, make room
    assign o_move = !i_occ || (r_pos > i_new_pos);

    always_comb begin
        n_pos    = r_pos;
        n_handle = r_handle;
        if (i_ctl.ins && o_move) begin
            if (i_left_move) begin
                n_pos    = i_left_pos;
                n_handle = i_left_handle;
            end else begin
                n_pos    = i_new_pos;
                n_handle = i_new_handle;
            end
        end else if (i_ctl.pop) begin
            n_pos    = i_right_pos;
            n_handle = i_right_handle;
        end
    end

    always_comb begin
        n_tap_pos    = r_tap_pos;
        n_tap_handle = r_tap_handle;
        if (i_ctl.tap_load) begin
            n_tap_pos    = r_pos;
            n_tap_handle = r_handle;
        end else if (i_ctl.tap_shift) begin
            n_tap_pos    = i_right_tap_pos;
            n_tap_handle = i_right_tap_handle;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_handle     <= n_handle;
        r_tap_pos    <= n_tap_pos;
        r_tap_handle <= n_tap_handle;
    end

    assign o_pos        = r_pos;
    assign o_handle     = r_handle;
    assign o_tap_pos    = r_tap_pos;
    assign o_tap_handle = r_tap_handle;

endmodule

### src/sorted_event_queue.sv
`timescale 1ns / 1ps
// sorted event queue top level: command control, count, capacity and the cell chain
// insert, get and clear: result in the cycle after the transfer, a new command every cycle
// peek at rank r: the result comes from the readout tap chain, loaded on the transfer,
//   that moves one rank toward the head per cycle; busy is high until the result
// failed commands give their result in the cycle after the transfer
// reset: queue empty, capacity equal to DEPTH; results cannot be stalled by the receiver
module sorted_event_queue #(
    parameter int DEPTH       = 64,
    parameter int HANDLE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [sevq_pkg::CMD_W-1:0]           i_command,
    input  logic [sevq_pkg::HANDLE_PORT_W-1:0]   i_event_handle,
    input  logic [sevq_pkg::POS_W-1:0]           i_position,
    input  logic [sevq_pkg::RANK_W-1:0]          i_peek_rank,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [sevq_pkg::CAP_W-1:0]           i_cfg_data,
    output logic                                 o_done,
    output logic                                 o_ok,
    output logic [sevq_pkg::HANDLE_PORT_W-1:0]   o_out_handle,
    output logic [sevq_pkg::POS_W-1:0]           o_out_position
);

    localparam int HPW = sevq_pkg::HANDLE_PORT_W;
    localparam int PW  = sevq_pkg::POS_W;
    localparam int SW  = (HANDLE_BITS < HPW) ? HANDLE_BITS : HPW;
    localparam int CW  = ($clog2(DEPTH + 1) > sevq_pkg::CAP_W) ?
                         $clog2(DEPTH + 1) : sevq_pkg::CAP_W;
    localparam int RW  = sevq_pkg::RANK_W;

    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    logic [CW-1:0]  r_cap;
    logic [CW-1:0]  n_cap;
    logic           r_busy;
    logic           n_busy;
    logic [RW-1:0]  r_left;
    logic [RW-1:0]  n_left;
    logic           r_done;
    logic           n_done;
    logic           r_ok;
    logic           n_ok;
    logic [HPW-1:0] r_oh;
    logic [HPW-1:0] n_oh;
    logic [PW-1:0]  r_op;
    logic [PW-1:0]  n_op;

    sevq_pkg::t_cell_ctl w_ctl;
    logic                w_accept;
    logic                w_cfg;
    logic [CW-1:0]       w_cfg_ext;
    logic [CW-1:0]       w_cap_clamp;

    logic [DEPTH-1:0] w_move;
    logic [DEPTH-1:0] w_occ;
    logic [PW-1:0]    w_pos      [DEPTH];
    logic [SW-1:0]    w_handle   [DEPTH];
    logic [PW-1:0]    w_tap_pos  [DEPTH];
    logic [SW-1:0]    w_tap_handle [DEPTH];

    assign w_accept    = start && !r_busy;
    assign w_cfg       = i_cfg_valid && o_cfg_ready;
    assign w_cfg_ext   = CW'(i_cfg_data);
    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;

    always_comb begin
        if (w_cfg_ext == '0) begin
            w_cap_clamp = CW'(1);
        end else if (w_cfg_ext > CW'(DEPTH)) begin
            w_cap_clamp = CW'(DEPTH);
        end else begin
            w_cap_clamp = w_cfg_ext;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic          w_lmove;
            logic [PW-1:0] w_lpos;
            logic [SW-1:0] w_lhandle;
            logic [PW-1:0] w_rpos;
            logic [SW-1:0] w_rhandle;
            logic [PW-1:0] w_rtpos;
            logic [SW-1:0] w_rthandle;

            assign w_occ[gi] = (CW'(gi) < r_count);

            if (gi == 0) begin : g_head
                assign w_lmove   = 1'b0;
                assign w_lpos    = w_pos[gi];
                assign w_lhandle = w_handle[gi];
            end else begin : g_body
                assign w_lmove   = w_move[gi-1];
                assign w_lpos    = w_pos[gi-1];
                assign w_lhandle = w_handle[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                assign w_rpos     = w_pos[gi];
                assign w_rhandle  = w_handle[gi];
                assign w_rtpos    = w_tap_pos[gi];
                assign w_rthandle = w_tap_handle[gi];
            end else begin : g_inner
                assign w_rpos     = w_pos[gi+1];
                assign w_rhandle  = w_handle[gi+1];
                assign w_rtpos    = w_tap_pos[gi+1];
                assign w_rthandle = w_tap_handle[gi+1];
            end

            sevq_cell #(
                .HW (SW)
            ) u_cell (
                .i_clk              (i_clk),
                .i_ctl              (w_ctl),
                .i_new_pos          (i_position),
                .i_new_handle       (i_event_handle[SW-1:0]),
                .i_occ              (w_occ[gi]),
                .i_left_move        (w_lmove),
                .i_left_pos         (w_lpos),
                .i_left_handle      (w_lhandle),
                .i_right_pos        (w_rpos),
                .i_right_handle     (w_rhandle),
                .i_right_tap_pos    (w_rtpos),
                .i_right_tap_handle (w_rthandle),
                .o_move             (w_move[gi]),
                .o_pos              (w_pos[gi]),
                .o_handle           (w_handle[gi]),
                .o_tap_pos          (w_tap_pos[gi]),
                .o_tap_handle       (w_tap_handle[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        n_cap   = r_cap;
        n_busy  = r_busy;
        n_left  = r_left;
        n_done  = 1'b0;
        n_ok    = 1'b0;
        n_oh    = '0;
        n_op    = '0;
        w_ctl   = '0;
        if (w_accept) begin
            case (i_command)
                sevq_pkg::CMD_INSERT: begin
                    n_done = 1'b1;
                    if (r_count < r_cap) begin
                        w_ctl.ins = 1'b1;
                        n_count   = r_count + CW'(1);
                        n_ok      = 1'b1;
                    end
                end
                sevq_pkg::CMD_GET: begin
                    n_done = 1'b1;
                    if (r_count != '0) begin
                        w_ctl.pop = 1'b1;
                        n_count   = r_count - CW'(1);
                        n_ok      = 1'b1;
                        n_oh      = HPW'(w_handle[0]);
                        n_op      = w_pos[0];
                    end
                end
                sevq_pkg::CMD_PEEK: begin
                    if (CW'(i_peek_rank) < r_count) begin
                        w_ctl.tap_load = 1'b1;
                        n_busy         = 1'b1;
                        n_left         = i_peek_rank;
                    end else begin
                        n_done = 1'b1;
                    end
                end
                sevq_pkg::CMD_CLEAR: begin
                    n_done  = 1'b1;
                    n_ok    = 1'b1;
                    n_count = '0;
                end
                default: begin
                    n_done = 1'b1;
                end
            endcase
        end else if (r_busy) begin
            if (r_left == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                n_ok   = 1'b1;
                n_oh   = HPW'(w_tap_handle[0]);
                n_op   = w_tap_pos[0];
            end else begin
                w_ctl.tap_shift = 1'b1;
                n_left          = r_left - RW'(1);
            end
        end
        if (w_cfg) begin
            n_cap   = w_cap_clamp;
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cap   <= CW'(DEPTH);
            r_busy  <= 1'b0;
            r_left  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_cap   <= n_cap;
            r_busy  <= n_busy;
            r_left  <= n_left;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok <= n_ok;
        r_oh <= n_oh;
        r_op <= n_op;
    end

    assign o_done         = r_done;
    assign o_ok           = r_ok;
    assign o_out_handle   = r_oh;
    assign o_out_position = r_op;

`ifndef NO_ASSERTIONS
    a_count_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_cap)
        else $error("entry count above capacity");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && !r_ok |-> r_oh == '0 && r_op == '0)
        else $error("failed command returned nonzero payload");

    a_quick_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_command != sevq_pkg::CMD_PEEK |=> r_done && !r_busy)
        else $error("command other than peek gave no result next cycle");

    a_peek_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_left == '0 |=> r_done && r_ok && !r_busy)
        else $error("peek readout did not finish");

    a_no_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_done)
        else $error("result shown while peek still in progress");
`endif

endmodule
